// ===== rtl/cfpc_pkg.sv =====
package cfpc_pkg;

  // field and register widths
  localparam int TEMP_W    = 16;
  localparam int PRES_W    = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // ramp duration in seconds: minutes * 60 fits 22 bits
  localparam int DUR_W = CFG_W + 6;

  // serial multiplier: multiplicand x multiplier, one multiplier bit per cycle
  localparam int MUL_A_W   = DUR_W;
  localparam int MUL_B_W   = 18;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // serial divider: one quotient bit per cycle
  localparam int DIV_D_W   = DUR_W;
  localparam int DIV_Q_W   = PRES_W;
  localparam int DIV_N_W   = DIV_D_W + DIV_Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // gain term: saturate at p >= 2^18, term = p*p >> 20
  localparam int GAIN_SAT_BIT = 18;
  localparam int TERM_SHIFT   = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND     = 3'd0,
    REG_MIN_PRESSURE = 3'd1,
    REG_MAX_PRESSURE = 3'd2,
    REG_RAMP_OFFSET  = 3'd3,
    REG_RAMP_MINUTES = 3'd4,
    REG_GAIN         = 3'd5
  } cfpc_reg_e;

  localparam logic [CFG_W-1:0] RST_DEADBAND     = 16'd64;
  localparam logic [CFG_W-1:0] RST_MIN_PRESSURE = 16'd0;
  localparam logic [CFG_W-1:0] RST_MAX_PRESSURE = 16'hFFFF;
  localparam logic [CFG_W-1:0] RST_RAMP_OFFSET  = 16'd0;
  localparam logic [CFG_W-1:0] RST_RAMP_MINUTES = 16'd1;
  localparam logic [CFG_W-1:0] RST_GAIN         = 16'd256;

  // setpoint bands in 1/64 K and base pressures in 1/256 mbar
  localparam logic [TEMP_W-1:0] SP_LIM_10K  = 16'd640;
  localparam logic [TEMP_W-1:0] SP_LIM_20K  = 16'd1280;
  localparam logic [TEMP_W-1:0] SP_LIM_50K  = 16'd3200;
  localparam logic [TEMP_W-1:0] SP_LIM_100K = 16'd6400;
  localparam logic [PRES_W-1:0] BASE_35MB   = 16'd8960;
  localparam logic [PRES_W-1:0] BASE_25MB   = 16'd6400;
  localparam logic [PRES_W-1:0] BASE_14MB   = 16'd3584;
  localparam logic [PRES_W-1:0] BASE_10MB   = 16'd2560;
  localparam logic [PRES_W-1:0] BASE_8MB    = 16'd2048;

  typedef struct packed {
    logic busy;
    logic done;
  } cfpc_unit_sts_t;

  function automatic logic [PRES_W-1:0] base_pressure(input logic [TEMP_W-1:0] sp);
    logic [PRES_W-1:0] res;
    if (sp < SP_LIM_10K) begin
      res = BASE_35MB;
    end else if (sp < SP_LIM_20K) begin
      res = BASE_25MB;
    end else if (sp < SP_LIM_50K) begin
      res = BASE_14MB;
    end else if (sp < SP_LIM_100K) begin
      res = BASE_10MB;
    end else begin
      res = BASE_8MB;
    end
    return res;
  endfunction

endpackage

// ===== rtl/cfpc_mul.sv =====
module cfpc_mul import cfpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MUL_A_W-1:0]   a_i,
  input  logic [MUL_B_W-1:0]   b_i,
  output logic [MUL_P_W-1:0]   prod_o,
  output cfpc_unit_sts_t       sts_o
);

  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_P_W-1:0]   p_q, p_d;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [MUL_A_W:0]     sum;

  // right-shift shift-add: multiplier sits in the low bits and drains out LSB first
  always_comb begin
    sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + {1'b0, a_q};
    if (p_q[0]) begin
      p_d = {sum, p_q[MUL_B_W-1:1]};
    end else begin
      p_d = {1'b0, p_q[MUL_P_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= MUL_CNT_W'(MUL_B_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MUL_A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign prod_o     = p_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/cfpc_div.sv =====
module cfpc_div import cfpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_N_W-1:0]   num_i,
  input  logic [DIV_D_W-1:0]   den_i,
  output logic [DIV_Q_W-1:0]   quo_o,
  output cfpc_unit_sts_t       sts_o
);

  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   den_q;
  logic [DIV_Q_W-1:0]   low_q, low_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_D_W:0]     trial, diff;
  logic                 ge;

  // restoring division; caller guarantees num >> DIV_Q_W < den, so the
  // quotient fits and the remainder always stays below den
  always_comb begin
    trial = {rem_q, low_q[DIV_Q_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    low_d = {low_q[DIV_Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(DIV_Q_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // low_q shifts dividend bits out at the top and quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DIV_N_W-1:DIV_Q_W];
      low_q <= num_i[DIV_Q_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign quo_o      = low_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/cryostat_flow_pressure_controller.sv =====
// The minimum and base cases go straight to the final sum and clamp; inside the deadband
// the elapsed ramp time is found first, then a serial multiply and a serial divide if a ramp
// division is needed; above the deadband one serial multiply when the gain term saturates, else two.
// One sample at a time; the next sample is taken the cycle after the result is
// registered, even while that result still waits on the output.
// Reset: asynchronous, active low; registers return to their defaults, ramp start to 0.
module cryostat_flow_pressure_controller import cfpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TEMP_W-1:0]    temperature_i,
  input  logic [TEMP_W-1:0]    setpoint_i,
  input  logic [TIME_W-1:0]    time_now_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PRES_W-1:0]    pressure_o,
  output logic [TIME_W-1:0]    ramp_start_out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_PREP2, S_RMUL, S_RDIV, S_GMUL1, S_GMUL2, S_GCLAMP, S_FIN, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    RG_MIN, RG_BASE, RG_IN, RG_ABOVE
  } region_e;

  // configuration
  logic [CFG_W-1:0] db_q, pmin_q, pmax_q, roff_q, rmin_q, gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q   <= RST_DEADBAND;
      pmin_q <= RST_MIN_PRESSURE;
      pmax_q <= RST_MAX_PRESSURE;
      roff_q <= RST_RAMP_OFFSET;
      rmin_q <= RST_RAMP_MINUTES;
      gain_q <= RST_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEADBAND:     db_q   <= cfg_data_i;
        REG_MIN_PRESSURE: pmin_q <= cfg_data_i;
        REG_MAX_PRESSURE: pmax_q <= cfg_data_i;
        REG_RAMP_OFFSET:  roff_q <= cfg_data_i;
        REG_RAMP_MINUTES: rmin_q <= cfg_data_i;
        REG_GAIN:         gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e             state_q;
  region_e            region_q, region_d;
  logic [PRES_W-1:0]  base_q, ramp_q, term_q, gcl_q;
  logic [PRES_W:0]    pre_q;
  logic [TIME_W-1:0]  now_q, el_q, ramp_start_q, rs_out_q;
  logic [DUR_W-1:0]   dur_q, dur_d;
  logic               before_q;
  logic               out_valid_q;
  logic [PRES_W-1:0]  pres_q;

  logic               in_acc;
  logic [TEMP_W:0]    dn;
  logic               sp_ge, over;
  logic [TEMP_W-1:0]  tms, mag, e_d;
  logic [PRES_W-1:0]  ramp_pass;

  // sample decode: delta = temperature - setpoint, dn = -delta
  always_comb begin
    dn    = {1'b0, setpoint_i} - {1'b0, temperature_i};
    tms   = temperature_i - setpoint_i;
    sp_ge = !dn[TEMP_W];
    mag   = sp_ge ? dn[TEMP_W-1:0] : tms;
    over  = mag > db_q;
    e_d   = mag - db_q;
    priority if (sp_ge && ({1'b0, dn[TEMP_W-1:0]} >= {db_q, 1'b0})) begin
      region_d = RG_MIN;
    end else if (sp_ge && (dn[TEMP_W-1:0] >= db_q)) begin
      region_d = RG_BASE;
    end else if (!sp_ge && over) begin
      region_d = RG_ABOVE;
    end else begin
      region_d = RG_IN;
    end
    dur_d     = {rmin_q, 6'b0} - {4'b0, rmin_q, 2'b0};
    // above the deadband the ramp restarts now, so it is at full offset
    ramp_pass = (rmin_q == '0) ? '0 : roff_q;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // serial units
  logic                 mul_start, div_start;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_prod;
  logic [DIV_Q_W-1:0]   div_quo;
  cfpc_unit_sts_t       mul_sts, div_sts;

  logic                 late, go_mul, sat;
  logic [DUR_W-1:0]     rem_time;

  always_comb begin
    late     = el_q >= {{(TIME_W-DUR_W){1'b0}}, dur_q};
    rem_time = dur_q - el_q[DUR_W-1:0];
    go_mul   = (rmin_q != '0) && !before_q && !late;
    sat      = |mul_prod[2*CFG_W-1:GAIN_SAT_BIT];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_IDLE: begin
        mul_a = MUL_A_W'(e_d);
        mul_b = MUL_B_W'(gain_q);
      end
      S_PREP2: begin
        mul_a = rem_time;
        mul_b = MUL_B_W'(roff_q);
      end
      S_GMUL1: begin
        mul_a = MUL_A_W'(mul_prod[GAIN_SAT_BIT-1:0]);
        mul_b = mul_prod[GAIN_SAT_BIT-1:0];
      end
      default: ;
    endcase
    mul_start = (in_acc && (region_d == RG_ABOVE))
             || ((state_q == S_PREP2) && go_mul)
             || ((state_q == S_GMUL1) && mul_sts.done && !sat);
    div_start = (state_q == S_RMUL) && mul_sts.done;
  end

  cfpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .sts_o   (mul_sts)
  );

  cfpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod[DIV_N_W-1:0]),
    .den_i   (dur_q),
    .quo_o   (div_quo),
    .sts_o   (div_sts)
  );

  // clamps
  logic [PRES_W:0]   gsum, pre_d;
  logic [PRES_W-1:0] glo, ghi, gcl_d, plo, phi, fin_d;

  always_comb begin
    gsum  = {1'b0, base_q} + {1'b0, term_q};
    glo   = (base_q <= pmax_q) ? base_q : pmax_q;
    ghi   = (base_q <= pmax_q) ? pmax_q : base_q;
    if (gsum < {1'b0, glo}) begin
      gcl_d = glo;
    end else if (gsum > {1'b0, ghi}) begin
      gcl_d = ghi;
    end else begin
      gcl_d = gsum[PRES_W-1:0];
    end

    unique case (region_q)
      RG_MIN:   pre_d = {1'b0, pmin_q};
      RG_BASE:  pre_d = {1'b0, base_q};
      RG_IN:    pre_d = {1'b0, base_q} + {1'b0, ramp_q};
      RG_ABOVE: pre_d = {1'b0, gcl_q} + {1'b0, ramp_q};
      default:  pre_d = '0;
    endcase

    plo = (pmin_q <= pmax_q) ? pmin_q : pmax_q;
    phi = (pmin_q <= pmax_q) ? pmax_q : pmin_q;
    if (pre_q < {1'b0, plo}) begin
      fin_d = plo;
    end else if (pre_q > {1'b0, phi}) begin
      fin_d = phi;
    end else begin
      fin_d = pre_q[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      region_q     <= RG_MIN;
      ramp_start_q <= '0;
      out_valid_q  <= 1'b0;
      base_q       <= '0;
      ramp_q       <= '0;
      term_q       <= '0;
      gcl_q        <= '0;
      pre_q        <= '0;
      now_q        <= '0;
      el_q         <= '0;
      dur_q        <= '0;
      before_q     <= 1'b0;
      pres_q       <= '0;
      rs_out_q     <= '0;
    end else begin
      // in S_OUT the output register is handled below
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            region_q <= region_d;
            base_q   <= base_pressure(setpoint_i);
            now_q    <= time_now_i;
            dur_q    <= dur_d;
            ramp_q   <= ramp_pass;
            if (over) begin
              ramp_start_q <= time_now_i;
            end
            unique case (region_d)
              RG_IN:    state_q <= S_PREP;
              RG_ABOVE: state_q <= S_GMUL1;
              default:  state_q <= S_FIN;
            endcase
          end
        end
        S_PREP: begin
          el_q     <= now_q - ramp_start_q;
          before_q <= now_q <= ramp_start_q;
          state_q  <= S_PREP2;
        end
        S_PREP2: begin
          if (rmin_q == '0) begin
            ramp_q  <= '0;
            state_q <= S_FIN;
          end else if (before_q) begin
            ramp_q  <= roff_q;
            state_q <= S_FIN;
          end else if (late) begin
            ramp_q  <= '0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_RMUL;
          end
        end
        S_RMUL: begin
          if (mul_sts.done) begin
            state_q <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_sts.done) begin
            ramp_q  <= div_quo;
            state_q <= S_FIN;
          end
        end
        S_GMUL1: begin
          if (mul_sts.done) begin
            if (sat) begin
              term_q  <= '1;
              state_q <= S_GCLAMP;
            end else begin
              state_q <= S_GMUL2;
            end
          end
        end
        S_GMUL2: begin
          if (mul_sts.done) begin
            term_q  <= mul_prod[TERM_SHIFT+PRES_W-1:TERM_SHIFT];
            state_q <= S_GCLAMP;
          end
        end
        S_GCLAMP: begin
          gcl_q   <= gcl_d;
          state_q <= S_FIN;
        end
        S_FIN: begin
          pre_q   <= pre_d;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            pres_q      <= fin_d;
            rs_out_q    <= ramp_start_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pressure_o       = pres_q;
  assign ramp_start_out_o = rs_out_q;

  a_rs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && over) |=> (ramp_start_q == $past(time_now_i)))
    else $error("ramp start not loaded on large error");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_sts.done |-> (state_q == S_RMUL || state_q == S_GMUL1 || state_q == S_GMUL2))
    else $error("multiplier finished outside a wait state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_RDIV))
    else $error("divider finished outside its wait state");

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
    else $error("serial unit busy while idle");

endmodule

// ===== tb/cfpc_demand_checker.sv =====
module cfpc_demand_checker import cfpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [TEMP_W-1:0]    temperature_i,
  input  logic [TEMP_W-1:0]    setpoint_i,
  input  logic [TIME_W-1:0]    time_now_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [PRES_W-1:0]    pressure_i,
  input  logic [TIME_W-1:0]    ramp_start_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o
);

  typedef struct packed {
    logic [PRES_W-1:0] pressure;
    logic [TIME_W-1:0] ramp_start;
  } demand_t;

  demand_t demand_q[$];
  demand_t oldest;

  // shadow of the block's registers and ramp state
  logic [CFG_W-1:0]  sh_deadband;
  logic [CFG_W-1:0]  sh_min;
  logic [CFG_W-1:0]  sh_max;
  logic [CFG_W-1:0]  sh_ramp_offset;
  logic [CFG_W-1:0]  sh_ramp_minutes;
  logic [CFG_W-1:0]  sh_gain;
  logic [TIME_W-1:0] sh_ramp_start;
  int unsigned       mismatches;

  function automatic logic [31:0] clamp_pair(logic [31:0] v, logic [31:0] a, logic [31:0] b);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] band_base(logic [TEMP_W-1:0] sp);
    logic [31:0] res;
    res = 32'(BASE_8MB);
    if (sp < SP_LIM_100K) res = 32'(BASE_10MB);
    if (sp < SP_LIM_50K)  res = 32'(BASE_14MB);
    if (sp < SP_LIM_20K)  res = 32'(BASE_25MB);
    if (sp < SP_LIM_10K)  res = 32'(BASE_35MB);
    return res;
  endfunction

  function automatic logic [31:0] ramp_extra(logic [TIME_W-1:0] now);
    logic [63:0] dur;
    logic [63:0] el;
    logic [63:0] start;
    logic [63:0] now_w;
    dur   = 64'(sh_ramp_minutes) * 64'd60;
    start = 64'(sh_ramp_start);
    now_w = 64'(now);
    if (dur == 64'd0) return 32'd0;
    if (now_w <= start) return 32'(sh_ramp_offset);
    el = now_w - start;
    if (el >= dur) return 32'd0;
    return 32'((64'(sh_ramp_offset) * (dur - el)) / dur);
  endfunction

  function automatic logic [31:0] boost_demand(longint delta, logic [31:0] base);
    longint      db;
    logic [63:0] excess;
    logic [63:0] prod;
    logic [63:0] term;
    db     = sh_deadband;
    excess = 64'(delta - db);
    prod   = excess * 64'(sh_gain);
    if (prod >= (64'd1 << GAIN_SAT_BIT)) begin
      term = 64'd65535;
    end else begin
      term = (prod * prod) >> TERM_SHIFT;
    end
    return clamp_pair(base + 32'(term), base, 32'(sh_max));
  endfunction

  task automatic predict_demand(logic [TEMP_W-1:0] temp, logic [TEMP_W-1:0] sp,
                                logic [TIME_W-1:0] now);
    longint      tl;
    longint      sl;
    longint      delta;
    longint      db;
    longint      mag;
    logic [31:0] base;
    logic [31:0] p;
    demand_t     d;
    tl    = temp;
    sl    = sp;
    db    = sh_deadband;
    delta = tl - sl;
    mag   = (delta < 0) ? -delta : delta;
    base  = band_base(sp);
    if (mag > db) sh_ramp_start = now;
    if (delta <= -2 * db) begin
      p = 32'(sh_min);
    end else if (delta <= -db) begin
      p = base;
    end else if (delta <= db) begin
      p = base + ramp_extra(now);
    end else begin
      p = boost_demand(delta, base) + ramp_extra(now);
    end
    p = clamp_pair(p, 32'(sh_min), 32'(sh_max));
    d.pressure   = p[PRES_W-1:0];
    d.ramp_start = sh_ramp_start;
    demand_q.push_back(d);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_deadband     = RST_DEADBAND;
      sh_min          = RST_MIN_PRESSURE;
      sh_max          = RST_MAX_PRESSURE;
      sh_ramp_offset  = RST_RAMP_OFFSET;
      sh_ramp_minutes = RST_RAMP_MINUTES;
      sh_gain         = RST_GAIN;
      sh_ramp_start   = '0;
      mismatches      = 0;
      demand_q.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEADBAND:     sh_deadband     = cfg_data_i;
          REG_MIN_PRESSURE: sh_min          = cfg_data_i;
          REG_MAX_PRESSURE: sh_max          = cfg_data_i;
          REG_RAMP_OFFSET:  sh_ramp_offset  = cfg_data_i;
          REG_RAMP_MINUTES: sh_ramp_minutes = cfg_data_i;
          REG_GAIN:         sh_gain         = cfg_data_i;
          default: ;
        endcase
      end
      // check the output beat first so a stray result can't match this cycle's input
      if (out_valid_i && !out_stall_i) begin
        if (demand_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result beat: pressure %0d ramp_start %0d",
                     pressure_i, ramp_start_i);
          end
        end else begin
          oldest = demand_q.pop_front();
          if (oldest.pressure !== pressure_i || oldest.ramp_start !== ramp_start_i) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("demand mismatch: expected pressure %0d ramp_start %0d, got %0d %0d",
                       oldest.pressure, oldest.ramp_start, pressure_i, ramp_start_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_demand(temperature_i, setpoint_i, time_now_i);
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= demand_q.size();
    end
  end

endmodule

// ===== tb/cryostat_flow_pressure_controller_test.sv =====
module cryostat_flow_pressure_controller_test;
  import cfpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [TEMP_W-1:0]    temperature;
  logic [TEMP_W-1:0]    setpoint;
  logic [TIME_W-1:0]    time_now;
  logic                 out_valid;
  logic                 out_stall;
  logic                 stall_rnd;
  logic                 stall_hold;
  logic [PRES_W-1:0]    pressure;
  logic [TIME_W-1:0]    ramp_start_out;
  int unsigned          mismatch_count;
  int unsigned          outstanding;

  logic        hold_go;
  logic        sender_calm;
  logic [31:0] clock_s;
  int          cur_deadband;

  assign out_stall = stall_rnd | stall_hold;

  cryostat_flow_pressure_controller dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .temperature_i    (temperature),
    .setpoint_i       (setpoint),
    .time_now_i       (time_now),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pressure_o       (pressure),
    .ramp_start_out_o (ramp_start_out)
  );

  cfpc_demand_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .temperature_i    (temperature),
    .setpoint_i       (setpoint),
    .time_now_i       (time_now),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pressure_i       (pressure),
    .ramp_start_i     (ramp_start_out),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stall bursts, mostly short, some long, some long open stretches
  initial begin
    int unsigned r;
    int unsigned len;
    stall_rnd <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        stall_rnd <= 1'b0;
        len = $urandom_range(1, 12);
      end else if (r < 60) begin
        stall_rnd <= 1'b0;
        len = $urandom_range(30, 120);
      end else if (r < 90) begin
        stall_rnd <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        stall_rnd <= 1'b1;
        len = $urandom_range(20, 60);
      end
      repeat (len) @(posedge clk);
    end
  end

  // one long hold-off so the block backs up and stalls its input
  initial begin
    stall_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (400) @(posedge clk);
    stall_hold <= 1'b0;
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] db, logic [CFG_W-1:0] mn,
                              logic [CFG_W-1:0] mx, logic [CFG_W-1:0] ro,
                              logic [CFG_W-1:0] rm, logic [CFG_W-1:0] g);
    set_reg(REG_DEADBAND, db);
    set_reg(REG_MIN_PRESSURE, mn);
    set_reg(REG_MAX_PRESSURE, mx);
    set_reg(REG_RAMP_OFFSET, ro);
    set_reg(REG_RAMP_MINUTES, rm);
    set_reg(REG_GAIN, g);
    cfg_we <= 1'b0;
    cur_deadband = db;
  endtask

  // drain the block before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_sample(logic [TEMP_W-1:0] t, logic [TEMP_W-1:0] sp,
                             logic [TIME_W-1:0] now);
    int unsigned r;
    int unsigned gap;
    in_valid    <= 1'b1;
    temperature <= t;
    setpoint    <= sp;
    time_now    <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = $urandom_range(0, 99);
    gap = 0;
    if (!sender_calm) begin
      if (r >= 92) gap = $urandom_range(15, 60);
      else if (r >= 60) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_edgy(int unsigned p_zero, int unsigned p_max,
                                                 int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < p_zero) return '0;
    if (r < p_zero + p_max) return '1;
    if (r < 90) return CFG_W'($urandom_range(lo, hi));
    return CFG_W'($urandom);
  endfunction

  function automatic logic [TEMP_W-1:0] pick_setpoint();
    logic [TEMP_W-1:0] sp;
    case ($urandom_range(0, 6))
      0: sp = TEMP_W'($urandom_range(0, 639));
      1: sp = TEMP_W'($urandom_range(640, 1279));
      2: sp = TEMP_W'($urandom_range(1280, 3199));
      3: sp = TEMP_W'($urandom_range(3200, 6399));
      4: sp = TEMP_W'($urandom_range(6400, 65535));
      5: begin
        case ($urandom_range(0, 3))
          0: sp = SP_LIM_10K;
          1: sp = SP_LIM_20K;
          2: sp = SP_LIM_50K;
          default: sp = SP_LIM_100K;
        endcase
        if ($urandom_range(0, 1) == 1) sp = sp - 1'b1;
      end
      default: sp = TEMP_W'($urandom);
    endcase
    return sp;
  endfunction

  function automatic int pick_delta(int db);
    int k;
    int a;
    int d;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      a = $urandom_range(0, 2 * db);
      d = a - db;
    end else if (k < 50) begin
      a = (db > 0) ? $urandom_range(0, db - 1) : 0;
      d = -db - a;
    end else if (k < 60) begin
      a = $urandom_range(0, 500);
      d = -2 * db - a;
    end else if (k < 85) begin
      a = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 80) : $urandom_range(0, 3000);
      d = db + 1 + a;
    end else begin
      case ($urandom_range(0, 5))
        0: d = -2 * db;
        1: d = -2 * db + 1;
        2: d = -db;
        3: d = -db + 1;
        4: d = db;
        default: d = db + 1;
      endcase
    end
    return d;
  endfunction

  task automatic random_samples(int n);
    int unsigned       r;
    int                tv;
    logic [TEMP_W-1:0] sp;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_sample(TEMP_W'($urandom), TEMP_W'($urandom), $urandom);
      end else begin
        sp = pick_setpoint();
        tv = int'(sp) + pick_delta(cur_deadband);
        if (tv < 0) tv = 0;
        if (tv > 65535) tv = 65535;
        r = $urandom_range(0, 99);
        if (r < 80) clock_s = clock_s + $urandom_range(0, 30);
        else if (r < 88) clock_s = clock_s + $urandom_range(100, 5000);
        else if (r < 94) clock_s = clock_s - $urandom_range(1, 200);
        else clock_s = $urandom;
        send_sample(TEMP_W'(tv), sp, clock_s);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    temperature <= '0;
    setpoint    <= '0;
    time_now    <= '0;
    hold_go      = 1'b0;
    sender_calm  = 1'b0;
    clock_s      = 32'd0;
    cur_deadband = RST_DEADBAND;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: every region and every setpoint band
    send_sample(16'd640, 16'd640, 32'd10);
    send_sample(16'd0, 16'hFFFF, 32'd20);
    send_sample(16'hFFFF, 16'd0, 32'd30);
    send_sample(16'd600, 16'd639, 32'd40);
    send_sample(16'd1216, 16'd1280, 32'd50);
    send_sample(16'd1152, 16'd1280, 32'd60);
    send_sample(16'd1345, 16'd1280, 32'd70);
    send_sample(16'd3299, 16'd3199, 32'd80);
    send_sample(16'd3264, 16'd3200, 32'd90);
    send_sample(16'd6399, 16'd6399, 32'd100);
    send_sample(16'd6400, 16'd6400, 32'd110);
    send_sample(16'd0, 16'd0, 32'hFFFF_FFFF);

    // ramp: start, time at start, half way, finished, time before start
    drain();
    program_regs(16'd10, 16'd100, 16'd60000, 16'd5000, 16'd2, 16'd1000);
    send_sample(16'd2000, 16'd1000, 32'd1000);
    send_sample(16'd1000, 16'd1000, 32'd1000);
    send_sample(16'd1005, 16'd1000, 32'd1060);
    send_sample(16'd995, 16'd1000, 32'd1120);
    send_sample(16'd1000, 16'd1000, 32'd500);

    // zero deadband, swapped limits, ramp off, unused register indexes
    drain();
    program_regs(16'd0, 16'd40000, 16'd1000, 16'hFFFF, 16'd0, 16'hFFFF);
    set_reg(REG_SPARE_A, 16'hFFFF);
    set_reg(REG_SPARE_B, 16'h0000);
    cfg_we <= 1'b0;
    send_sample(16'd1000, 16'd1000, 32'd2000);
    send_sample(16'd1001, 16'd1000, 32'd2001);

    drain();
    program_regs(16'hFFFF, 16'd0, 16'd100, 16'd0, 16'hFFFF, 16'd0);
    send_sample(16'hFFFF, 16'd0, 32'd3000);
    send_sample(16'd0, 16'hFFFF, 32'd3001);

    // max below the base
    drain();
    program_regs(16'd5, 16'd0, 16'd100, 16'd0, 16'd1, 16'd300);
    send_sample(16'd700, 16'd640, 32'd4000);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      program_regs(pick_edgy(10, 5, 1, 200),
                   pick_edgy(15, 10, 0, 3000),
                   ($urandom_range(0, 3) == 0) ? pick_edgy(10, 10, 0, 3000)
                                               : pick_edgy(5, 25, 40000, 65535),
                   pick_edgy(15, 10, 1, 65535),
                   pick_edgy(15, 5, 1, 5),
                   pick_edgy(10, 10, 0, 4000));
      if ($urandom_range(0, 3) == 0) begin
        set_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        cfg_we <= 1'b0;
      end
      if ($urandom_range(0, 4) == 0) clock_s = 32'hFFFF_F000;
      sender_calm = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        sender_calm = 1'b1;
        hold_go     = 1'b1;
      end
      random_samples(150);
    end

    drain();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
